>>> rtl/smrf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smrf_pkg
// shared constants, mode and register codes, and the burst metadata type
// for the square matrix rotate / flip core
// ----------------------------------------------------------------------------
package smrf_pkg;

  localparam int MAX_DIM     = 8;
  localparam int DATA_W      = 32;
  localparam int DIM_W       = 4;
  localparam int MODE_W      = 3;
  localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // transform codes
  localparam logic [MODE_W-1:0] MODE_MIRROR_ROWS = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FLIP_ROWS   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TRANSPOSE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROT90       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ROT180      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ROT270      = 3'd5;

  // register indexes
  localparam logic REG_DIMENSION = 1'b0;
  localparam logic REG_MODE      = 1'b1;

  // position of one result item in the emitted matrix
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } smrf_meta_t;

endpackage
`default_nettype wire

>>> rtl/smrf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smrf_ram
// generic simple dual-port ram, one write port, one read port with
// registered read data that holds while read enable is low
// ----------------------------------------------------------------------------
module smrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/smrf_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smrf_seq
// burst address sequencer: walks result positions row-major and maps each
// one to its source entry in the store for the latched transform
// ----------------------------------------------------------------------------
module smrf_seq
  import smrf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIM_W-1:0]  dim,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic              issue,
  output logic                   active,
  output logic      [ADDR_W-1:0] raddr,
  output smrf_meta_t             meta
);

  localparam int PROD_W = IDX_W + DIM_W;

  logic [DIM_W-1:0]  n_lat;
  logic [MODE_W-1:0] mode_lat;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  nm1;
  logic [IDX_W-1:0]  rr;
  logic [IDX_W-1:0]  rc;
  logic [IDX_W-1:0]  sr;
  logic [IDX_W-1:0]  sc;
  logic [PROD_W-1:0] prod;
  logic              last;

  always_comb begin
    nm1 = IDX_W'(n_lat - DIM_W'(1));
    rr  = nm1 - row;
    rc  = nm1 - col;
    case (mode_lat)
      MODE_MIRROR_ROWS: begin sr = row; sc = rc;  end
      MODE_FLIP_ROWS:   begin sr = rr;  sc = col; end
      MODE_TRANSPOSE:   begin sr = col; sc = row; end
      MODE_ROT90:       begin sr = rc;  sc = row; end
      MODE_ROT180:      begin sr = rr;  sc = rc;  end
      MODE_ROT270:      begin sr = col; sc = rr;  end
      default:          begin sr = row; sc = col; end  // unused codes: identity
    endcase
    prod  = PROD_W'(sr) * PROD_W'(n_lat);
    raddr = ADDR_W'(prod + PROD_W'(sc));
    last  = (row == nm1) && (col == nm1);
    meta  = '{row: row, col: col, last: last};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      row    <= '0;
      col    <= '0;
    end else if (start) begin
      active <= 1'b1;
      row    <= '0;
      col    <= '0;
    end else if (issue) begin
      if (col == nm1) begin
        col <= '0;
        row <= row + IDX_W'(1);
      end else begin
        col <= col + IDX_W'(1);
      end
      if (last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_lat    <= dim;
      mode_lat <= mode;
    end
  end

endmodule
`default_nettype wire

>>> rtl/square_matrix_rotate_flip_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// square_matrix_rotate_flip_core
// loads an n x n matrix row-major and emits it mirrored, flipped,
// transposed or rotated, row-major, with tlast on the final element
// ----------------------------------------------------------------------------
// Elements arrive on the s_ stream, one per cycle while s_tready is high,
// and are written into a 64-entry store at consecutive addresses. The
// element that completes the matrix (load count reaching dimension squared,
// with dimension 0 read as 1 and values above 8 read as 8) starts a burst: a
// sequencer walks the result positions row-major, maps each to its source
// entry and reads the store, one read a cycle while the output does not
// stall. Each of the n*n burst items passes the store read register and the
// output register, one item per cycle while m_tready is high, set by the
// single read port of the store. s_tready is low while burst reads are being
// issued. Results carry their row and column in the result matrix. Modes 6
// and 7 pass the matrix unchanged. The store has no reset; the user must
// write configuration only while idle, and the block does not enforce it.
// ----------------------------------------------------------------------------
module square_matrix_rotate_flip_core
  import smrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] element
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [31:0] out_element, [34:32] out_row,
                                      // [37:35] out_col, [39:38] zero
  output logic             m_tlast,   // out_last
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int TOT_W = 2 * DIM_W;

  // configuration registers
  logic [DIM_W-1:0]  dimension;
  logic [MODE_W-1:0] mode;
  logic              cfg_we;
  logic              cfg_sel;

  // load side
  logic [CNT_W-1:0]  load_count;
  logic [CNT_W-1:0]  load_count_next;
  logic [DIM_W-1:0]  eff_dim;
  logic [TOT_W-1:0]  total;
  logic              s_accept;
  logic              start;

  // burst side
  logic              gen_active;
  logic              issue;
  logic              move;
  logic [ADDR_W-1:0] raddr;
  smrf_meta_t        seq_meta;
  logic              pend;
  smrf_meta_t        pend_meta;
  logic [DATA_W-1:0] rdata;

  // output register
  logic              out_valid;
  logic [DATA_W-1:0] out_element;
  smrf_meta_t        out_meta;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_W'(MAX_DIM);
      mode      <= MODE_MIRROR_ROWS;
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_DIMENSION: dimension <= pwdata[DIM_W-1:0];
        REG_MODE:      mode      <= pwdata[MODE_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_DIMENSION: prdata = 32'(dimension);
      REG_MODE:      prdata = 32'(mode);
      default:       prdata = '0;
    endcase
  end

  // ---------------- load side ----------------
  // zero reads as one, anything above the maximum saturates
  always_comb begin
    if (dimension == '0) begin
      eff_dim = DIM_W'(1);
    end else if (dimension > DIM_W'(MAX_DIM)) begin
      eff_dim = DIM_W'(MAX_DIM);
    end else begin
      eff_dim = dimension;
    end
    total = TOT_W'(eff_dim) * TOT_W'(eff_dim);
  end

  assign s_tready        = !gen_active;
  assign s_accept        = s_tvalid && s_tready;
  assign load_count_next = load_count + CNT_W'(1);
  // compare with >= so a dimension lowered mid-load still closes the matrix
  assign start           = s_accept && (TOT_W'(load_count_next) >= total);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (s_accept) begin
      load_count <= start ? '0 : load_count_next;
    end
  end

  smrf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (s_accept),
    .waddr (load_count[ADDR_W-1:0]),
    .wdata (s_tdata),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ---------------- burst side ----------------
  smrf_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .dim    (eff_dim),
    .mode   (mode),
    .issue  (issue),
    .active (gen_active),
    .raddr  (raddr),
    .meta   (seq_meta)
  );

  // ram read register acts as a skid slot: it holds while the output stalls
  assign move  = pend && (!out_valid || m_tready);
  assign issue = gen_active && (!pend || move);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (issue) begin
      pend <= 1'b1;
    end else if (move) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_meta <= seq_meta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_element <= rdata;
      out_meta    <= pend_meta;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_meta.col, out_meta.row, out_element};
  assign m_tlast  = out_meta.last;

  // ---------------- assertions ----------------
  // no element is taken while burst reads are still being issued
  a_no_load_in_burst: assert property (@(posedge clk) disable iff (rst)
    !(gen_active && s_accept))
    else $error("element accepted during burst");

  // load count stays below the store depth between matrices
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    load_count < CNT_W'(STORE_DEPTH))
    else $error("load count out of range");

  // the final item sits on the diagonal corner
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_meta.last) |-> (out_meta.row == out_meta.col))
    else $error("last item not at corner");

  // a read is only issued when its slot is free at the next edge
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (pend && !move) |=> ($stable(rdata) && pend))
    else $error("pending read data overwritten");

endmodule
`default_nettype wire
